// File: rtl/cli_pkg.sv
package cli_pkg;

    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 4;
    localparam int ARG_W   = 16;
    localparam int UPC_W   = 5;
    localparam int POS_W   = 3;
    localparam int ERR_LEN = 15;
    localparam int ERR_K_W = 4;
    localparam int NUM_CMDS = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [APB_AW-1:0] REG_MODE_ADDR = 3'h0;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_CAN   = 8'h18;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

    // two-letter command names, index order
    localparam logic [2*CHAR_W-1:0] CMD_ROM [NUM_CMDS] = '{
        16'h4C53, 16'h564E, 16'h454E, 16'h4144, 16'h4441, 16'h4348,
        16'h4750, 16'h4454, 16'h5743, 16'h5452, 16'h5458
    };

    // "! Command Error"
    localparam logic [CHAR_W-1:0] ERR_TEXT [ERR_LEN] = '{
        8'h21, 8'h20, 8'h43, 8'h6F, 8'h6D, 8'h6D, 8'h61, 8'h6E,
        8'h64, 8'h20, 8'h45, 8'h72, 8'h72, 8'h6F, 8'h72
    };

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_NOP,
        OP_JNI,
        OP_JNM,
        OP_EMIT,
        OP_ERR,
        OP_DISP,
        OP_STORE
    } op_t;

    typedef enum logic [1:0] {
        SEL_RX,
        SEL_CR,
        SEL_LF,
        SEL_GT
    } csel_t;

    typedef struct packed {
        op_t              op;
        upc_t             nxt;
        csel_t            csel;
        logic             last;
        logic             rd_en;
        logic [POS_W-1:0] rd_pos;
        logic             cap_c1;
        logic             cap_c2;
        logic             lookup;
        logic             acc_clr;
        logic             dig_hex;
        logic             dig_dec;
        logic             clr;
    } ucw_t;

    typedef struct packed {
        ucw_t w;
        logic go;
        logic take;
    } ctl_t;

    typedef struct packed {
        logic out_free;
        logic match;
        logic err_done;
        logic line_empty;
    } sts_t;

    // program entry points
    localparam upc_t L_IDLE    = 5'd0;
    localparam upc_t L_PRINT   = 5'd1;
    localparam upc_t L_ESC     = 5'd4;
    localparam upc_t L_PROMPT  = 5'd5;
    localparam upc_t L_RUN     = 5'd8;
    localparam upc_t L_TEST    = 5'd16;
    localparam upc_t L_DISP    = 5'd20;
    localparam upc_t L_NOMATCH = 5'd21;
    localparam upc_t L_TAIL    = 5'd25;

    function automatic ucw_t ucode_rom(input upc_t pc);
        ucw_t w;
        w      = '0;
        w.op   = OP_WAIT;
        w.nxt  = L_IDLE;
        w.csel = SEL_RX;
        case (pc)
            L_PRINT:      begin w.op = OP_STORE; w.nxt = L_PRINT + 5'd1; end
            L_PRINT + 1:  begin w.op = OP_JNI;   w.nxt = L_IDLE; end
            L_PRINT + 2:  begin w.op = OP_EMIT;  w.csel = SEL_RX; w.last = 1'b1; end
            L_ESC:        begin w.op = OP_NOP;   w.clr = 1'b1; w.nxt = L_PROMPT; end
            L_PROMPT:     begin w.op = OP_EMIT;  w.csel = SEL_CR; w.nxt = L_PROMPT + 5'd1; end
            L_PROMPT + 1: begin w.op = OP_EMIT;  w.csel = SEL_LF; w.nxt = L_PROMPT + 5'd2; end
            L_PROMPT + 2: begin w.op = OP_EMIT;  w.csel = SEL_GT; w.last = 1'b1; end
            L_RUN:
            begin
                w.op = OP_NOP; w.rd_en = 1'b1; w.rd_pos = 3'd0; w.nxt = L_RUN + 5'd1;
            end
            L_RUN + 1:
            begin
                w.op = OP_NOP; w.rd_en = 1'b1; w.rd_pos = 3'd1; w.cap_c1 = 1'b1;
                w.nxt = L_RUN + 5'd2;
            end
            L_RUN + 2:
            begin
                w.op = OP_NOP; w.rd_en = 1'b1; w.rd_pos = 3'd3; w.cap_c2 = 1'b1;
                w.acc_clr = 1'b1; w.nxt = L_RUN + 5'd3;
            end
            L_RUN + 3:
            begin
                w.op = OP_NOP; w.rd_en = 1'b1; w.rd_pos = 3'd4; w.lookup = 1'b1;
                w.dig_hex = 1'b1; w.dig_dec = 1'b1; w.nxt = L_RUN + 5'd4;
            end
            L_RUN + 4:
            begin
                w.op = OP_NOP; w.rd_en = 1'b1; w.rd_pos = 3'd5;
                w.dig_hex = 1'b1; w.dig_dec = 1'b1; w.nxt = L_RUN + 5'd5;
            end
            L_RUN + 5:
            begin
                w.op = OP_NOP; w.rd_en = 1'b1; w.rd_pos = 3'd6;
                w.dig_hex = 1'b1; w.dig_dec = 1'b1; w.nxt = L_RUN + 5'd6;
            end
            L_RUN + 6:
            begin
                w.op = OP_NOP; w.rd_en = 1'b1; w.rd_pos = 3'd7;
                w.dig_hex = 1'b1; w.dig_dec = 1'b1; w.nxt = L_RUN + 5'd7;
            end
            L_RUN + 7:    begin w.op = OP_NOP; w.dig_dec = 1'b1; w.nxt = L_TEST; end
            L_TEST:       begin w.op = OP_JNM;  w.nxt = L_NOMATCH; end
            L_TEST + 1:   begin w.op = OP_JNI;  w.nxt = L_DISP; end
            L_TEST + 2:   begin w.op = OP_EMIT; w.csel = SEL_CR; w.nxt = L_TEST + 5'd3; end
            L_TEST + 3:   begin w.op = OP_EMIT; w.csel = SEL_LF; w.nxt = L_DISP; end
            L_DISP:       begin w.op = OP_DISP; w.nxt = L_TAIL; end
            L_NOMATCH:    begin w.op = OP_JNI;  w.nxt = L_TAIL; end
            L_NOMATCH + 1:
            begin
                w.op = OP_EMIT; w.csel = SEL_CR; w.nxt = L_NOMATCH + 5'd2;
            end
            L_NOMATCH + 2:
            begin
                w.op = OP_EMIT; w.csel = SEL_LF; w.nxt = L_NOMATCH + 5'd3;
            end
            L_NOMATCH + 3: begin w.op = OP_ERR; w.nxt = L_TAIL; end
            L_TAIL:        begin w.op = OP_NOP; w.clr = 1'b1; w.nxt = L_PROMPT; end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [IDX_W:0] cmd_lookup(input logic [CHAR_W-1:0] c1,
                                                  input logic [CHAR_W-1:0] c2);
        logic [IDX_W:0] r;
        r = '0;
        for (int n = NUM_CMDS - 1; n >= 0; n--)
        begin
            if (CMD_ROM[n] == {c1, c2})
            begin
                r = {1'b1, IDX_W'(n)};
            end
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
        if (c inside {[8'h61:8'h7A]})
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [CHAR_W-1:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            return {1'b1, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'b0;
    endfunction

endpackage

// File: rtl/cli_rx_if.sv
interface cli_rx_if
    import cli_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

// File: rtl/cli_tx_if.sv
interface cli_tx_if
    import cli_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAR_W-1:0] out_char;
    logic [IDX_W-1:0]  command_index;
    logic [ARG_W-1:0]  hex_argument;
    logic              hex_present;
    logic [ARG_W-1:0]  dec_argument;
    logic              dec_present;
    logic [CHAR_W-1:0] arg_char;
    logic              last;

    modport source (output valid, output kind, output out_char, output command_index,
                    output hex_argument, output hex_present, output dec_argument,
                    output dec_present, output arg_char, output last, input ready);
    modport sink   (input valid, input kind, input out_char, input command_index,
                    input hex_argument, input hex_present, input dec_argument,
                    input dec_present, input arg_char, input last, output ready);
endinterface

// File: rtl/cli_useq.sv
module cli_useq
    import cli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode,
    input  logic              in_valid,
    input  logic [CHAR_W-1:0] rx_char,
    output logic              in_ready,
    input  sts_t              sts,
    output ctl_t              ctl
);

    upc_t pc_reg;
    upc_t pc_next;
    ucw_t w;

    assign w = ucode_rom(pc_reg);

    always_comb
    begin
        pc_next  = pc_reg;
        in_ready = 1'b0;
        ctl.w    = w;
        ctl.go   = 1'b0;
        ctl.take = 1'b0;
        case (w.op)
            OP_WAIT:
            begin
                in_ready = 1'b1;
                ctl.take = in_valid;
                if (in_valid)
                begin
                    // entry point chosen by the class of the received byte
                    if (rx_char == CH_CR)
                    begin
                        pc_next = sts.line_empty ? L_PROMPT : L_RUN;
                    end
                    else if (rx_char inside {[CH_SPACE:CH_TILDE]})
                    begin
                        pc_next = L_PRINT;
                    end
                    else if (rx_char == CH_ESC || rx_char == CH_CAN)
                    begin
                        pc_next = L_ESC;
                    end
                end
            end
            OP_NOP, OP_STORE:
            begin
                ctl.go  = 1'b1;
                pc_next = w.nxt;
            end
            OP_JNI:
            begin
                ctl.go  = 1'b1;
                pc_next = mode ? pc_reg + upc_t'(1) : w.nxt;
            end
            OP_JNM:
            begin
                ctl.go  = 1'b1;
                pc_next = sts.match ? pc_reg + upc_t'(1) : w.nxt;
            end
            OP_EMIT, OP_DISP:
            begin
                ctl.go = sts.out_free;
                if (sts.out_free)
                begin
                    pc_next = w.nxt;
                end
            end
            OP_ERR:
            begin
                ctl.go = sts.out_free;
                if (sts.out_free && sts.err_done)
                begin
                    pc_next = w.nxt;
                end
            end
            default:
            begin
                pc_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= L_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: rtl/cli_dpath.sv
module cli_dpath
    import cli_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] rx_char,
    input  ctl_t              ctl,
    output sts_t              sts,
    cli_tx_if.source          tx
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);

    logic [CHAR_W-1:0] mem [LINE_DEPTH];

    logic [CHAR_W-1:0]  rx_reg;
    logic [FW-1:0]      fill_reg;
    logic [CHAR_W-1:0]  rdata_reg;
    logic [POS_W-1:0]   rdpos_reg;
    logic [CHAR_W-1:0]  c1_reg;
    logic [CHAR_W-1:0]  c2_reg;
    logic               match_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CHAR_W-1:0]  arg_reg;
    logic [ARG_W-1:0]   hex_reg;
    logic [ARG_W-1:0]   dec_reg;
    logic               hex_go_reg;
    logic               dec_go_reg;
    logic [ERR_K_W-1:0] err_k_reg;

    logic               vld_reg;
    logic               kind_reg;
    logic [CHAR_W-1:0]  ch_reg;
    logic [IDX_W-1:0]   cidx_reg;
    logic [ARG_W-1:0]   hexo_reg;
    logic               hexp_reg;
    logic [ARG_W-1:0]   deco_reg;
    logic               decp_reg;
    logic [CHAR_W-1:0]  argo_reg;
    logic               last_reg;

    logic               store_en;
    logic               emit;
    logic               out_free;
    logic [CHAR_W-1:0]  buf_val;
    logic [4:0]         hv;
    logic [IDX_W:0]     hit;
    logic [CHAR_W-1:0]  sel_char;
    logic [ARG_W-1:0]   dec_mul;

    assign out_free = !vld_reg || tx.ready;
    assign store_en = ctl.go && ctl.w.op == OP_STORE && fill_reg < FW'(LINE_DEPTH);
    assign emit     = ctl.go && (ctl.w.op == OP_EMIT || ctl.w.op == OP_ERR
                                 || ctl.w.op == OP_DISP);

    // positions past the fill point read as zero, so no clearing pass is needed
    assign buf_val = (FW'(rdpos_reg) < fill_reg) ? rdata_reg : '0;
    assign hv      = hex_val(buf_val);
    assign hit     = cmd_lookup(c1_reg, c2_reg);
    assign dec_mul = (dec_reg << 3) + (dec_reg << 1);

    always_comb
    begin
        case (ctl.w.csel)
            SEL_RX:  sel_char = rx_reg;
            SEL_CR:  sel_char = CH_CR;
            SEL_LF:  sel_char = CH_LF;
            SEL_GT:  sel_char = CH_GT;
            default: sel_char = rx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[fill_reg[AW-1:0]] <= rx_reg;
        end
        if (ctl.go && ctl.w.rd_en)
        begin
            rdata_reg <= mem[AW'(ctl.w.rd_pos)];
            rdpos_reg <= ctl.w.rd_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            rx_reg <= rx_char;
        end
        if (ctl.go && ctl.w.cap_c1)
        begin
            c1_reg <= upcase(buf_val);
        end
        if (ctl.go && ctl.w.cap_c2)
        begin
            c2_reg <= upcase(buf_val);
        end
        if (ctl.go && ctl.w.lookup)
        begin
            match_reg <= hit[IDX_W];
            idx_reg   <= hit[IDX_W-1:0];
            arg_reg   <= buf_val;
        end
        if (ctl.go && ctl.w.acc_clr)
        begin
            hex_reg    <= '0;
            dec_reg    <= '0;
            hex_go_reg <= 1'b1;
            dec_go_reg <= 1'b1;
        end
        else
        begin
            if (ctl.go && ctl.w.dig_hex && hex_go_reg)
            begin
                if (hv[4])
                begin
                    hex_reg <= {hex_reg[ARG_W-5:0], hv[3:0]};
                end
                else
                begin
                    hex_go_reg <= 1'b0;
                end
            end
            if (ctl.go && ctl.w.dig_dec && dec_go_reg)
            begin
                if (is_digit(buf_val))
                begin
                    dec_reg <= dec_mul + ARG_W'(buf_val[3:0]);
                end
                else
                begin
                    dec_go_reg <= 1'b0;
                end
            end
        end
        if (emit)
        begin
            if (ctl.w.op == OP_DISP)
            begin
                kind_reg <= 1'b1;
                ch_reg   <= '0;
                cidx_reg <= idx_reg;
                hexo_reg <= hex_reg;
                hexp_reg <= hex_val(arg_reg) >> 4 != 5'd0;
                deco_reg <= dec_reg;
                decp_reg <= is_digit(arg_reg);
                argo_reg <= arg_reg;
                last_reg <= 1'b0;
            end
            else
            begin
                kind_reg <= 1'b0;
                ch_reg   <= (ctl.w.op == OP_ERR) ? ERR_TEXT[err_k_reg] : sel_char;
                cidx_reg <= '0;
                hexo_reg <= '0;
                hexp_reg <= 1'b0;
                deco_reg <= '0;
                decp_reg <= 1'b0;
                argo_reg <= '0;
                last_reg <= ctl.w.op == OP_EMIT && ctl.w.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            err_k_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.go && ctl.w.clr)
            begin
                fill_reg <= '0;
            end
            else if (store_en)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            if (ctl.go && ctl.w.op == OP_ERR)
            begin
                err_k_reg <= sts.err_done ? '0 : err_k_reg + ERR_K_W'(1);
            end
            if (emit)
            begin
                vld_reg <= 1'b1;
            end
            else if (tx.ready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free   = out_free;
    assign sts.match      = match_reg;
    assign sts.err_done   = err_k_reg == ERR_K_W'(ERR_LEN - 1);
    assign sts.line_empty = fill_reg == '0;

    assign tx.valid         = vld_reg;
    assign tx.kind          = kind_reg;
    assign tx.out_char      = ch_reg;
    assign tx.command_index = cidx_reg;
    assign tx.hex_argument  = hexo_reg;
    assign tx.hex_present   = hexp_reg;
    assign tx.dec_argument  = deco_reg;
    assign tx.dec_present   = decp_reg;
    assign tx.arg_char      = argo_reg;
    assign tx.last          = last_reg;

    a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.go && ctl.w.clr |=> fill_reg == '0)
        else $error("line not empty after clear");

    a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
        store_en && !ctl.w.clr |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("fill count did not advance on store");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result loaded over a pending transfer");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(LINE_DEPTH))
        else $error("fill count past line depth");

endmodule

// File: rtl/command_line_interpreter.sv
// Serial command line parser.
// rx: one received byte per transfer. tx: result items, each either a
// character for the host (kind 0) or a command dispatch (kind 1) carrying the
// command index, parsed hex and decimal arguments and the raw argument byte;
// last marks the final result caused by one received byte.
// APB register 0 (interactive_mode, reset 1) enables echo, the newline before
// a dispatch and the error text; write it only while the block is idle.
// A microcoded sequencer runs one short program per received byte and accepts
// the next byte only when that program has finished. A step that produces a
// result waits until the tx output register is free, so one result per cycle
// at most. For CR on a command line, eight steps read line positions 0, 1
// and 3 to 7 and parse them, then up to 20 results follow.
// Reset empties the line and returns the sequencer to waiting; no clearing
// pass is needed since the fill count masks stale buffer entries.
// A stalled tx holds the result; the sequencer freezes when it reaches a step
// that produces a result, and rx stays not ready while it is frozen.
module command_line_interpreter
    import cli_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    cli_rx_if.sink            rx,
    cli_tx_if.source          tx
);

    logic mode_reg;
    logic in_ready;
    sts_t sts;
    ctl_t ctl;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MODE_ADDR) ? APB_DW'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && paddr == REG_MODE_ADDR)
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign rx.ready = in_ready;

    cli_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .in_valid (rx.valid),
        .rx_char  (rx.rx_char),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    cli_dpath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_char (rx.rx_char),
        .ctl     (ctl),
        .sts     (sts),
        .tx      (tx)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench
    import cli_pkg::*;
;

    localparam int LINE_DEPTH      = 32;
    localparam int SETTLE_CYCLES   = 40;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int NUM_PHASES      = 8;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] out_char;
        logic [IDX_W-1:0]  command_index;
        logic [ARG_W-1:0]  hex_argument;
        logic              hex_present;
        logic [ARG_W-1:0]  dec_argument;
        logic              dec_present;
        logic [CHAR_W-1:0] arg_char;
        logic              last;
    } tx_item_t;

    class cli_scoreboard;
        logic [CHAR_W-1:0] line_buf [LINE_DEPTH];
        int unsigned       fill_cnt;
        bit                interactive;
        tx_item_t          awaited [$];
        tx_item_t          burst [$];
        int                errors;

        function new();
            clear_line();
            interactive = 1'b1;
            errors      = 0;
        endfunction

        function void clear_line();
            foreach (line_buf[i])
            begin
                line_buf[i] = '0;
            end
            fill_cnt = 0;
        endfunction

        function logic [CHAR_W-1:0] line_at(int pos);
            if (pos < LINE_DEPTH)
            begin
                return line_buf[pos];
            end
            return '0;
        endfunction

        function logic [CHAR_W-1:0] to_upper(logic [CHAR_W-1:0] c);
            if (c >= 8'h61 && c <= 8'h7A)
            begin
                return c - 8'h20;
            end
            return c;
        endfunction

        // {is hex digit, nibble}
        function logic [4:0] hex_digit(logic [CHAR_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                return {1'b1, 4'(c - 8'h30)};
            end
            if (c >= 8'h41 && c <= 8'h46)
            begin
                return {1'b1, 4'(c - 8'h41 + 8'd10)};
            end
            if (c >= 8'h61 && c <= 8'h66)
            begin
                return {1'b1, 4'(c - 8'h61 + 8'd10)};
            end
            return '0;
        endfunction

        function void push_char(logic [CHAR_W-1:0] c);
            tx_item_t r;
            r          = '0;
            r.out_char = c;
            burst.push_back(r);
        endfunction

        function void push_prompt();
            push_char(CH_CR);
            push_char(CH_LF);
            push_char(CH_GT);
        endfunction

        function void push_dispatch(int idx);
            tx_item_t          r;
            logic [ARG_W-1:0]  hexv;
            logic [ARG_W-1:0]  decv;
            logic [CHAR_W-1:0] a;
            logic [CHAR_W-1:0] c;
            logic [4:0]        h;
            hexv = '0;
            decv = '0;
            a    = line_at(3);
            for (int i = 0; i < 4; i++)
            begin
                h = hex_digit(line_at(3 + i));
                if (!h[4])
                begin
                    break;
                end
                hexv = {hexv[ARG_W-5:0], h[3:0]};
            end
            for (int i = 0; i < 5; i++)
            begin
                c = line_at(3 + i);
                if (c < 8'h30 || c > 8'h39)
                begin
                    break;
                end
                decv = ARG_W'(decv * 10 + (c - 8'h30));
            end
            h               = hex_digit(a);
            r               = '0;
            r.kind          = 1'b1;
            r.command_index = IDX_W'(idx);
            r.hex_argument  = hexv;
            r.hex_present   = h[4];
            r.dec_argument  = decv;
            r.dec_present   = (a >= 8'h30 && a <= 8'h39);
            r.arg_char      = a;
            burst.push_back(r);
        endfunction

        function void run_line();
            logic [CHAR_W-1:0] c1;
            logic [CHAR_W-1:0] c2;
            int                idx;
            c1  = to_upper(line_at(0));
            c2  = to_upper(line_at(1));
            idx = -1;
            for (int n = 0; n < NUM_CMDS; n++)
            begin
                if (idx < 0 && CMD_ROM[n] == {c1, c2})
                begin
                    idx = n;
                end
            end
            if (idx >= 0)
            begin
                if (interactive)
                begin
                    push_char(CH_CR);
                    push_char(CH_LF);
                end
                push_dispatch(idx);
            end
            else if (interactive)
            begin
                push_char(CH_CR);
                push_char(CH_LF);
                for (int k = 0; k < ERR_LEN; k++)
                begin
                    push_char(ERR_TEXT[k]);
                end
            end
            push_prompt();
            clear_line();
        endfunction

        // returns 1 when the byte is not simply ignored
        function bit note_byte(logic [CHAR_W-1:0] c);
            bit acts;
            acts = 1'b1;
            burst.delete();
            if (c == CH_CR)
            begin
                if (fill_cnt != 0)
                begin
                    run_line();
                end
                else
                begin
                    push_prompt();
                end
            end
            else if (c >= CH_SPACE && c <= CH_TILDE)
            begin
                if (fill_cnt < LINE_DEPTH)
                begin
                    line_buf[fill_cnt] = c;
                    fill_cnt++;
                end
                if (interactive)
                begin
                    push_char(c);
                end
            end
            else if (c == CH_ESC || c == CH_CAN)
            begin
                clear_line();
                push_prompt();
            end
            else
            begin
                acts = 1'b0;
            end
            if (burst.size() > 0)
            begin
                burst[burst.size() - 1].last = 1'b1;
            end
            foreach (burst[i])
            begin
                awaited.push_back(burst[i]);
            end
            return acts;
        endfunction

        function string show(tx_item_t r);
            return $sformatf("kind=%0d char=%h cmd=%0d hex=%h/%0d dec=%h/%0d arg=%h last=%0d",
                             r.kind, r.out_char, r.command_index, r.hex_argument,
                             r.hex_present, r.dec_argument, r.dec_present, r.arg_char,
                             r.last);
        endfunction

        function void check_result(tx_item_t got);
            tx_item_t want;
            if (awaited.size() == 0)
            begin
                if (errors < REPORT_LIMIT)
                begin
                    $display("unexpected transfer at %0t: %s", $realtime, show(got));
                end
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.out_char !== want.out_char ||
                got.command_index !== want.command_index ||
                got.hex_argument !== want.hex_argument ||
                got.hex_present !== want.hex_present ||
                got.dec_argument !== want.dec_argument ||
                got.dec_present !== want.dec_present ||
                got.arg_char !== want.arg_char || got.last !== want.last)
            begin
                if (errors < REPORT_LIMIT)
                begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cli_rx_if rx_bus ();
    cli_tx_if tx_bus ();

    cli_scoreboard board;
    int            idle_pct;
    int            stall_pct;
    int            acted;

    always #6 clk = ~clk;

    command_line_interpreter dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (rx_bus),
        .tx      (tx_bus)
    );

    always @(negedge clk)
    begin
        tx_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_bus.valid && tx_bus.ready)
        begin
            board.check_result('{tx_bus.kind, tx_bus.out_char, tx_bus.command_index,
                                 tx_bus.hex_argument, tx_bus.hex_present,
                                 tx_bus.dec_argument, tx_bus.dec_present,
                                 tx_bus.arg_char, tx_bus.last});
        end
    end

    task automatic send_byte(input logic [CHAR_W-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            rx_bus.valid <= 1'b0;
            @(negedge clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_char <= b;
        @(posedge clk);
        while (!rx_bus.ready)
        begin
            @(posedge clk);
        end
        if (board.note_byte(b))
        begin
            acted++;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        rx_bus.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (board.awaited.size() != 0);
    endtask

    // ignored bytes leave no trace, so give the sequencer time to finish
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input bit m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MODE_ADDR;
        pwdata  <= APB_DW'(m);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        board.interactive = m;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] any_printable();
        return CHAR_W'($urandom_range(CH_TILDE, CH_SPACE));
    endfunction

    function automatic logic [CHAR_W-1:0] mixed_case(logic [CHAR_W-1:0] c);
        if ($urandom_range(1) != 0)
        begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] arg_byte();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return CHAR_W'(8'h30 + $urandom_range(9));
            5, 6:          return mixed_case(CHAR_W'(8'h41 + $urandom_range(5)));
            7:             return mixed_case(CHAR_W'(8'h47 + $urandom_range(19)));
            default:       return any_printable();
        endcase
    endfunction

    // mostly well-formed command lines with random arguments, some noise
    task automatic send_line();
        logic [CHAR_W-1:0] seq [$];
        int                r;
        int                idx;
        int                len;
        r = $urandom_range(99);
        if (r < 75)
        begin
            if (r < 60)
            begin
                idx = $urandom_range(NUM_CMDS - 1);
                seq.push_back(mixed_case(CMD_ROM[idx][15:8]));
                seq.push_back(mixed_case(CMD_ROM[idx][7:0]));
            end
            else
            begin
                seq.push_back(any_printable());
                seq.push_back(any_printable());
            end
            seq.push_back(($urandom_range(3) == 0) ? any_printable() : CH_SPACE);
            case ($urandom_range(9))
                0:
                begin
                    // may run past the end of the line buffer
                    len = $urandom_range(40, 28);
                    while (seq.size() < len)
                    begin
                        seq.push_back(any_printable());
                    end
                end
                1:
                begin
                    repeat (5) seq.push_back(CHAR_W'(8'h30 + $urandom_range(9)));
                end
                default:
                begin
                    len = $urandom_range(7);
                    repeat (len) seq.push_back(arg_byte());
                end
            endcase
        end
        else if (r < 85)
        begin
            if ($urandom_range(1) != 0)
            begin
                seq.push_back(any_printable());
            end
        end
        else
        begin
            repeat ($urandom_range(4, 1)) seq.push_back(CHAR_W'($urandom_range(255)));
            foreach (seq[i])
            begin
                send_byte(seq[i]);
            end
            return;
        end
        r = $urandom_range(99);
        seq.push_back((r < 90) ? CH_CR : (r < 95) ? CH_ESC : CH_CAN);
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
    endtask

    initial
    begin
        logic [CHAR_W-1:0] directed [];
        int  target;
        int  half;
        bit  paused;
        directed = '{
            CH_CR, 8'h00, 8'h7F, 8'h80, 8'hFF,
            "C", "h", " ", "f", "F", "9", "1", "9", "9", CH_CR,
            "Z", "Z", CH_CR, CH_ESC, CH_SPACE, CH_TILDE, CH_CR, CH_CAN
        };
        board          = new();
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_char = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        acted          = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_mode(1'b1);
        foreach (directed[i])
        begin
            send_byte(directed[i]);
        end
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_mode(phase[0] ^ phase[2]);
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 71; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            target = acted + ITEMS_PER_PHASE;
            half   = acted + ITEMS_PER_PHASE / 2;
            paused = 1'b0;
            while (acted < target)
            begin
                send_line();
                if (!paused && acted >= half)
                begin
                    // sender holds off until the output side has caught up
                    wait_drained();
                    paused = 1'b1;
                end
            end
            settle();
        end

        if (board.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/cli_pkg.sv
rtl/cli_rx_if.sv
rtl/cli_tx_if.sv
rtl/cli_useq.sv
rtl/cli_dpath.sv
rtl/command_line_interpreter.sv
verif/testbench.sv
